FILE: sv/ses_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ses_pkg: shared types and constants of the Schrodinger stencil step
// Cell and result payloads, register indexes, grid limits and the record that
// carries Laplacian terms from the window logic to the update arithmetic.
// ----------------------------------------------------------------------------
package ses_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MIN_DIM    = 3;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = 11;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int COEF_W     = 18;
  localparam int STEP_W     = 16;

  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int PEND_W = $clog2(QDEPTH + 1);

  localparam int LAP_W = 18;
  localparam int ACC_W = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_COEF_X      = 3'd2,
    CFG_COEF_Y      = 3'd3,
    CFG_TIME_STEP   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] psi_real;
    logic signed [15:0] psi_imag;
    logic signed [15:0] cell_potential;
  } cell_in_t;

  typedef struct packed {
    logic signed [15:0] new_real;
    logic signed [15:0] new_imag;
    logic               frame_last;
  } result_t;

  typedef struct packed {
    logic [COEF_W-1:0] coef_x;
    logic [COEF_W-1:0] coef_y;
    logic [STEP_W-1:0] time_step;
  } coef_t;

  typedef struct packed {
    logic signed [LAP_W-1:0] lxr;
    logic signed [LAP_W-1:0] lxi;
    logic signed [LAP_W-1:0] lyr;
    logic signed [LAP_W-1:0] lyi;
    logic signed [15:0]      cre;
    logic signed [15:0]      cim;
    logic signed [15:0]      cv;
    logic                    last;
  } lap_t;

endpackage

FILE: sv/schrodinger_euler_stencil_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schrodinger_euler_stencil_step: streaming 2D Schrodinger Euler step
// Takes grid cells in raster order and returns the updated interior cells.
// ----------------------------------------------------------------------------
// Usage:
//   Cells (psi_real, psi_imag, cell_potential) enter on the in_ channel, one
//   transfer per cell, row 0 first and column 0 first within a row. For each
//   interior cell one result transfer leaves on the out_ channel; boundary
//   cells produce nothing. frame_last marks the last interior cell of a frame.
//   Registers are to be written by the user through the cfg_ port only while
//   the block is idle; the block itself has no check for this. Throughput is
//   one cell per clock while in_stall is low. The rate is set by the line
//   store access: both line stores are read at the cell's column on the
//   transfer edge and written back on the next cycle, so each cell occupies
//   one read and one write slot. out_valid rises after the cell that completes
//   a stencil has passed the store read on the transfer edge, the Laplacian,
//   the two multiplier stages and the result queue.
//   When the receiver stalls, results collect in an eight-entry queue;
//   in_stall rises once eight results are owed, so no result is dropped.
//   Reset restores the register defaults (256 by 256 grid, zero coefficients),
//   returns the raster position to the first cell and clears the window. The
//   line stores are not cleared; the first two rows of a frame fill them.
// ----------------------------------------------------------------------------
module schrodinger_euler_stencil_step (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ses_pkg::cell_in_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ses_pkg::result_t               out_data,
  input  logic                           cfg_we,
  input  logic [ses_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ses_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ses_pkg::*;

  // Configuration registers.
  logic [DIM_W-1:0]  grid_width_r, grid_height_r;
  logic [COEF_W-1:0] coef_x_r, coef_y_r;
  logic [STEP_W-1:0] time_step_r;
  coef_t             coef;

  // Effective grid size, clamped to at least MIN_DIM and to what the line stores can hold.
  logic [DIM_W-1:0] w_eff, h_eff;

  logic    accept, out_accept, emit_now;
  logic    lap_valid, res_valid;
  lap_t    lap;
  result_t res;

  // Results owed to the receiver: counted at an input transfer that completes a
  // stencil, released at the output transfer. This bounds the queue occupancy.
  logic [PEND_W-1:0] pending_r, pending_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(256);
      grid_height_r <= DIM_W'(256);
      coef_x_r      <= '0;
      coef_y_r      <= '0;
      time_step_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data[DIM_W-1:0];
        CFG_COEF_X:      coef_x_r      <= cfg_data[COEF_W-1:0];
        CFG_COEF_Y:      coef_y_r      <= cfg_data[COEF_W-1:0];
        CFG_TIME_STEP:   time_step_r   <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign coef = '{coef_x: coef_x_r, coef_y: coef_y_r, time_step: time_step_r};

  assign w_eff = (grid_width_r < DIM_W'(MIN_DIM))   ? DIM_W'(MIN_DIM) :
                 (grid_width_r > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH) : grid_width_r;
  assign h_eff = (grid_height_r < DIM_W'(MIN_DIM))  ? DIM_W'(MIN_DIM) :
                 (grid_height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : grid_height_r;

  assign in_stall   = (pending_r >= PEND_W'(QDEPTH));
  assign accept     = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  always_comb begin
    pending_nxt = pending_r;
    if ((accept && emit_now) && !out_accept) begin
      pending_nxt = pending_r + PEND_W'(1);
    end else if (out_accept && !(accept && emit_now)) begin
      pending_nxt = pending_r - PEND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  ses_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cell_data (in_data),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .emit_now  (emit_now),
    .lap_valid (lap_valid),
    .lap       (lap)
  );

  ses_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .lap_valid (lap_valid),
    .lap       (lap),
    .coef      (coef),
    .res_valid (res_valid),
    .res       (res)
  );

  ses_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/ses_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ses_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ses_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/ses_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ses_window: raster counters, line stores and the stencil window
// Reads both line stores at the accepted cell's column, writes them back in the
// next cycle and forms the four Laplacian terms of the interior cell.
// ----------------------------------------------------------------------------
module ses_window (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  ses_pkg::cell_in_t         cell_data,
  input  logic [ses_pkg::DIM_W-1:0] w_eff,
  input  logic [ses_pkg::DIM_W-1:0] h_eff,
  output logic                      emit_now,
  output logic                      lap_valid,
  output ses_pkg::lap_t             lap
);
  import ses_pkg::*;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } pair_t;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_inc, row_inc;
  logic             inside_now, last_now;

  logic             s1_vld_r, s1_inside_r, s1_emit_r, s1_last_r;
  logic [COL_W-1:0] s1_col_r;
  cell_in_t         s1_cell_r;

  cell_in_t recent_rdata, east;
  pair_t    older_rdata, north_now, older_wdata;
  pair_t    west_r, north_r, prev_r;
  cell_in_t mid_r;

  logic             lap_vld_r;
  lap_t             lap_r;
  logic [LAP_W-1:0] lxr, lxi, lyr, lyi;

  // Position of the arriving cell.
  assign inside_now = ({1'b0, col_r} < w_eff) && ({1'b0, row_r} < h_eff);
  assign emit_now   = inside_now && (col_r >= COL_W'(2)) && (row_r >= ROW_W'(2));
  assign last_now   = ({1'b0, col_r} == w_eff - DIM_W'(1)) &&
                      ({1'b0, row_r} == h_eff - DIM_W'(1));

  assign col_inc = {1'b0, col_r} + DIM_W'(1);
  assign row_inc = {1'b0, row_r} + DIM_W'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_inside_r <= inside_now;
      s1_emit_r   <= emit_now;
      s1_last_r   <= last_now;
      s1_col_r    <= col_r;
      s1_cell_r   <= cell_data;
    end
  end

  // Consecutive cells touch neighboring columns, so a read and the write of
  // the previous cell never meet at one entry.
  assign older_wdata = '{re: recent_rdata.psi_real, im: recent_rdata.psi_imag};

  ses_ram #(.WIDTH($bits(cell_in_t)), .DEPTH(MAX_WIDTH)) u_recent_ram (
    .clk   (clk),
    .we    (s1_vld_r && s1_inside_r),
    .waddr (s1_col_r),
    .wdata (s1_cell_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (recent_rdata)
  );

  ses_ram #(.WIDTH($bits(pair_t)), .DEPTH(MAX_WIDTH)) u_older_ram (
    .clk   (clk),
    .we    (s1_vld_r && s1_inside_r),
    .waddr (s1_col_r),
    .wdata (older_wdata),
    .re    (accept),
    .raddr (col_r),
    .rdata (older_rdata)
  );

  assign east      = s1_inside_r ? recent_rdata : '0;
  assign north_now = s1_inside_r ? older_rdata : '0;

  assign lxr = {{2{west_r.re[15]}}, west_r.re} + {{2{east.psi_real[15]}}, east.psi_real}
             - {mid_r.psi_real[15], mid_r.psi_real, 1'b0};
  assign lxi = {{2{west_r.im[15]}}, west_r.im} + {{2{east.psi_imag[15]}}, east.psi_imag}
             - {mid_r.psi_imag[15], mid_r.psi_imag, 1'b0};
  assign lyr = {{2{north_r.re[15]}}, north_r.re} + {{2{prev_r.re[15]}}, prev_r.re}
             - {mid_r.psi_real[15], mid_r.psi_real, 1'b0};
  assign lyi = {{2{north_r.im[15]}}, north_r.im} + {{2{prev_r.im[15]}}, prev_r.im}
             - {mid_r.psi_imag[15], mid_r.psi_imag, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      west_r    <= '0;
      north_r   <= '0;
      prev_r    <= '0;
      mid_r     <= '0;
      lap_vld_r <= 1'b0;
    end else begin
      lap_vld_r <= s1_vld_r && s1_emit_r;
      if (s1_vld_r) begin
        west_r  <= '{re: mid_r.psi_real, im: mid_r.psi_imag};
        mid_r   <= east;
        north_r <= north_now;
        prev_r  <= '{re: s1_cell_r.psi_real, im: s1_cell_r.psi_imag};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      lap_r.lxr  <= lxr;
      lap_r.lxi  <= lxi;
      lap_r.lyr  <= lyr;
      lap_r.lyi  <= lyi;
      lap_r.cre  <= mid_r.psi_real;
      lap_r.cim  <= mid_r.psi_imag;
      lap_r.cv   <= mid_r.cell_potential;
      lap_r.last <= s1_last_r;
    end
  end

  assign lap_valid = lap_vld_r;
  assign lap       = lap_r;

endmodule

FILE: sv/ses_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ses_update: Euler update arithmetic
// Two multiplier stages and a final add, round and saturate to Q2.14.
// ----------------------------------------------------------------------------
module ses_update (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              lap_valid,
  input  ses_pkg::lap_t     lap,
  input  ses_pkg::coef_t    coef,
  output logic              res_valid,
  output ses_pkg::result_t  res
);
  import ses_pkg::*;

  localparam int PROD_W = COEF_W + LAP_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DV_W   = STEP_W + 17;
  localparam int DVC_W  = DV_W + 16;

  // First stage: coefficient products and dt*V.
  logic                     m1_vld_r;
  logic signed [PROD_W-1:0] px_r_r, py_r_r, px_i_r, py_i_r;
  logic signed [DV_W-1:0]   dv_r;
  logic signed [15:0]       m1_cre_r, m1_cim_r;
  logic                     m1_last_r;

  // Second stage: summed Laplacian terms and the potential products.
  logic                     m2_vld_r;
  logic signed [SUM_W-1:0]  sum_r_r, sum_i_r;
  logic signed [DVC_W-1:0]  dvc_r, dvr_r;
  logic signed [15:0]       m2_cre_r, m2_cim_r;
  logic                     m2_last_r;

  logic [ACC_W-1:0] acc_re, acc_im;
  logic [15:0]      sat_re, sat_im;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else begin
      m1_vld_r <= lap_valid;
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lap_valid) begin
      px_r_r    <= $signed({1'b0, coef.coef_x}) * lap.lxr;
      py_r_r    <= $signed({1'b0, coef.coef_y}) * lap.lyr;
      px_i_r    <= $signed({1'b0, coef.coef_x}) * lap.lxi;
      py_i_r    <= $signed({1'b0, coef.coef_y}) * lap.lyi;
      dv_r      <= $signed({1'b0, coef.time_step}) * lap.cv;
      m1_cre_r  <= lap.cre;
      m1_cim_r  <= lap.cim;
      m1_last_r <= lap.last;
    end
  end

  always_ff @(posedge clk) begin
    if (m1_vld_r) begin
      sum_r_r   <= {px_r_r[PROD_W-1], px_r_r} + {py_r_r[PROD_W-1], py_r_r};
      sum_i_r   <= {px_i_r[PROD_W-1], px_i_r} + {py_i_r[PROD_W-1], py_i_r};
      dvc_r     <= dv_r * m1_cim_r;
      dvr_r     <= dv_r * m1_cre_r;
      m2_cre_r  <= m1_cre_r;
      m2_cim_r  <= m1_cim_r;
      m2_last_r <= m1_last_r;
    end
  end

  // The center term carries the half-LSB rounding constant in its low bits.
  assign acc_re = {{(ACC_W - 40){m2_cre_r[15]}}, m2_cre_r, 1'b1, 23'd0}
                - {{(ACC_W - SUM_W - 8){sum_i_r[SUM_W-1]}}, sum_i_r, 8'd0}
                + {{(ACC_W - DVC_W){dvc_r[DVC_W-1]}}, dvc_r};
  assign acc_im = {{(ACC_W - 40){m2_cim_r[15]}}, m2_cim_r, 1'b1, 23'd0}
                + {{(ACC_W - SUM_W - 8){sum_r_r[SUM_W-1]}}, sum_r_r, 8'd0}
                - {{(ACC_W - DVC_W){dvr_r[DVC_W-1]}}, dvr_r};

  function automatic logic [15:0] saturate(input logic [ACC_W-1:0] acc);
    logic [ACC_W-25:0] q;
    q = acc[ACC_W-1:24];
    if (!q[ACC_W-25] && (|q[ACC_W-26:15])) begin
      return 16'h7FFF;
    end else if (q[ACC_W-25] && !(&q[ACC_W-26:15])) begin
      return 16'h8000;
    end else begin
      return q[15:0];
    end
  endfunction

  assign sat_re = saturate(acc_re);
  assign sat_im = saturate(acc_im);

  assign res_valid      = m2_vld_r;
  assign res.new_real   = sat_re;
  assign res.new_imag   = sat_im;
  assign res.frame_last = m2_last_r;

endmodule

FILE: sv/ses_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ses_queue: result queue
// A small register FIFO that decouples the update pipeline from the receiver.
// ----------------------------------------------------------------------------
module ses_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ses_pkg::result_t push_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ses_pkg::result_t out_data
);
  import ses_pkg::*;

  result_t           q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PEND_W-1:0] count_r, count_nxt;
  logic              pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = q_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + PEND_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - PEND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
